@@ design/mmc_pkg.sv @@
// types and constants shared by the min/max calibration block
package mmc_pkg;

	localparam int DATA_W = 16;
	localparam logic [DATA_W-1:0] SAMPLES_RESET = 16'd1000;

	typedef struct packed {
		logic signed [DATA_W-1:0] x_sample;
		logic signed [DATA_W-1:0] y_sample;
	} sample_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] x_bias;
		logic signed [DATA_W-1:0] y_bias;
		logic        [DATA_W-1:0] x_scale;
		logic        [DATA_W-1:0] y_scale;
		logic                     range_error;
	} result_t;

endpackage

@@ design/mag_min_max_calibration_unit.sv @@
// top level: per-axis min/max tracking, bit-serial divider and multiplier for scale and offset
// a sample that does not end a run is taken at once, back to back
// the sample that ends a run starts a busy phase before its result beat shows:
//   per axis a restoring division (one quotient bit a cycle), then
//   per axis a shift-add multiplication (one scale bit a cycle), then one load
// sample_stall stays high during that time and, at its end, until a previous result beat is taken
// arst_n clears extrema, sample counter and control; samples_per_run resets to 1000
module mag_min_max_calibration_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            sample_valid,
	output logic            sample_stall,
	input  mmc_pkg::sample_t sample,
	output logic            result_valid,
	input  logic            result_stall,
	output mmc_pkg::result_t result,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [mmc_pkg::DATA_W-1:0] cfg_data
);

	localparam int W     = mmc_pkg::DATA_W;
	localparam int ACC_W = 2 * W + 2;
	localparam int CNT_W = $clog2(W);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOAD  = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_SCALE = 3'd3;
	localparam logic [2:0] S_MLOAD = 3'd4;
	localparam logic [2:0] S_MUL   = 3'd5;
	localparam logic [2:0] S_MSAT  = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);
	localparam logic signed [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

	logic [2:0]       state_q;
	logic             ph_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     spr_q;
	logic [W-1:0]     run_count_q;
	logic signed [W-1:0] x_hi_q, x_lo_q, y_hi_q, y_lo_q;
	logic             result_valid_q;

	logic [W-1:0]     dvd_q, dsr_q, rem_q;
	logic signed [ACC_W-1:0] mcand_q, acc_q;
	logic [W-1:0]     mplr_q;
	logic [W-1:0]     xs_q, ys_q;
	logic signed [W-1:0] xo_q, yo_q;
	logic             err_q;
	mmc_pkg::result_t result_q;

	logic             take;
	logic [W-1:0]     count_next;
	logic             run_end;
	logic [W-1:0]     x_rng, y_rng;
	logic signed [W:0] x_diff, y_diff;
	logic [W+1:0]     trial;
	logic             qbit;
	logic [W-1:0]     scale_val;
	logic             dsr_zero;
	logic             sat_ovf;
	logic signed [W-1:0] sat_val;

	assign take         = sample_valid && !sample_stall;
	assign sample_stall = (state_q != S_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign count_next = run_count_q + 1'b1;
	assign run_end    = (count_next >= spr_q);

	assign x_rng  = W'(x_hi_q - x_lo_q);
	assign y_rng  = W'(y_hi_q - y_lo_q);
	assign x_diff = $signed({2'b00, x_rng[W-1:1]}) - $signed({x_hi_q[W-1], x_hi_q});
	assign y_diff = $signed({2'b00, y_rng[W-1:1]}) - $signed({y_hi_q[W-1], y_hi_q});

	assign trial     = {1'b0, rem_q, dvd_q[W-1]} - {2'b00, dsr_q};
	assign qbit      = !trial[W+1];
	assign dsr_zero  = (dsr_q == '0);
	assign scale_val = (dsr_zero || dvd_q == '0) ? W'(1) : dvd_q;

	assign sat_ovf = !((&acc_q[ACC_W-1:W-1]) || !(|acc_q[ACC_W-1:W-1]));
	assign sat_val = sat_ovf ? (acc_q[ACC_W-1] ? SAT_MIN : SAT_MAX) : acc_q[W-1:0];

	// control, extrema and counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			ph_q           <= 1'b0;
			cnt_q          <= '0;
			spr_q          <= mmc_pkg::SAMPLES_RESET;
			run_count_q    <= '0;
			x_hi_q         <= '0;
			x_lo_q         <= '0;
			y_hi_q         <= '0;
			y_lo_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				spr_q <= cfg_data;
			end
			if (result_valid_q && !result_stall && state_q != S_DONE) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						if (sample.x_sample < x_lo_q) begin
							x_lo_q <= sample.x_sample;
						end else if (sample.x_sample > x_hi_q) begin
							x_hi_q <= sample.x_sample;
						end
						if (sample.y_sample < y_lo_q) begin
							y_lo_q <= sample.y_sample;
						end else if (sample.y_sample > y_hi_q) begin
							y_hi_q <= sample.y_sample;
						end
						if (run_end) begin
							run_count_q <= '0;
							ph_q        <= 1'b0;
							state_q     <= S_LOAD;
						end else begin
							run_count_q <= count_next;
						end
					end
				end
				S_LOAD: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= S_SCALE;
					end
				end
				S_SCALE: begin
					ph_q    <= !ph_q;
					state_q <= ph_q ? S_MLOAD : S_LOAD;
				end
				S_MLOAD: begin
					cnt_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= S_MSAT;
					end
				end
				S_MSAT: begin
					ph_q    <= !ph_q;
					state_q <= ph_q ? S_DONE : S_MLOAD;
				end
				S_DONE: begin
					if (!result_valid_q || !result_stall) begin
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// serial datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_LOAD: begin
				dvd_q <= ph_q ? x_rng : y_rng;
				dsr_q <= ph_q ? y_rng : x_rng;
				rem_q <= '0;
			end
			S_DIV: begin
				if (qbit) begin
					rem_q <= trial[W-1:0];
				end else begin
					rem_q <= {rem_q[W-2:0], dvd_q[W-1]};
				end
				dvd_q <= {dvd_q[W-2:0], qbit};
			end
			S_SCALE: begin
				if (ph_q) begin
					ys_q  <= scale_val;
					err_q <= err_q || dsr_zero;
				end else begin
					xs_q  <= scale_val;
					err_q <= dsr_zero;
				end
			end
			S_MLOAD: begin
				mcand_q <= ACC_W'(ph_q ? y_diff : x_diff);
				mplr_q  <= ph_q ? ys_q : xs_q;
				acc_q   <= '0;
			end
			S_MUL: begin
				if (mplr_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q <= mcand_q <<< 1;
				mplr_q  <= mplr_q >> 1;
			end
			S_MSAT: begin
				if (ph_q) begin
					yo_q <= sat_val;
				end else begin
					xo_q <= sat_val;
				end
			end
			S_DONE: begin
				if (!result_valid_q || !result_stall) begin
					result_q.x_bias      <= xo_q;
					result_q.y_bias      <= yo_q;
					result_q.x_scale     <= xs_q;
					result_q.y_scale     <= ys_q;
					result_q.range_error <= err_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ design/mmc_checker.sv @@
// port-level checks for the min/max calibration block, bound to the top level
module mmc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             sample_stall,
	input logic             result_valid,
	input logic             result_stall,
	input mmc_pkg::result_t result
);

	// a stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// a new result appears only after the block was busy
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(sample_stall))
		else $error("result beat appeared without a busy phase");

	// scales are never zero
	a_scale_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.x_scale != '0) && (result.y_scale != '0))
		else $error("zero scale in result beat");

	// a zero range forces its scale to one
	a_error_scale: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.range_error |->
			(result.x_scale == 16'd1) || (result.y_scale == 16'd1))
		else $error("range error without a unit scale");

endmodule

bind mag_min_max_calibration_unit mmc_checker u_mmc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_stall (sample_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
